### rtl/csem_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csem_pkg
// Operation and status codes and counter limits for the semaphore table.
// ----------------------------------------------------------------------------
package csem_pkg;

	typedef enum logic [2:0] {
		OP_CREATE  = 3'd0,
		OP_WAIT    = 3'd1,
		OP_TRY     = 3'd2,
		OP_SIGNAL  = 3'd3,
		OP_SIGNALN = 3'd4,
		OP_COUNT   = 3'd5,
		OP_DELETE  = 3'd6,
		OP_RESET   = 3'd7
	} op_t;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_INVALID   = 3'd1,
		ST_OVERFLOW  = 3'd2,
		ST_UNAVAIL   = 3'd3,
		ST_BLOCKED   = 3'd4,
		ST_WOKEN     = 3'd5,
		ST_WOKEN_DEL = 3'd6,
		ST_WOKEN_RST = 3'd7
	} status_t;

	localparam logic signed [16:0] CNT_MIN = -17'sd32768;
	localparam logic signed [16:0] CNT_MAX = 17'sd32767;

endpackage

### rtl/counting_semaphore_table_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// counting_semaphore_table_core
// Counting semaphores with FIFO wait queues; one result per cycle at most.
// Create, wait, try_wait, count and every error finish in S_EXEC. Signal and
// signal_n then dequeue one woken process at a time (S_DQ, S_DQ_EM); delete
// and reset walk the links, then pop the waiters in reverse (S_WALK, S_POP),
// each step bound by a registered memory read.
// Throughput: one transaction at a time; busy is high until the last result.
// Reset: asynchronous, clears all control state; no memory clearing pass.
// ----------------------------------------------------------------------------
module counting_semaphore_table_core
	import csem_pkg::*;
#(
	parameter int NUM_SEMS  = 16,
	parameter int NUM_PROCS = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [2:0]         operation,
	input  logic [7:0]         sem_id,
	input  logic signed [15:0] amount,
	input  logic [5:0]         caller_pid,
	output logic               strobe,
	output logic [2:0]         status,
	output logic [15:0]        value,
	output logic [5:0]         woken_pid,
	output logic               last
);

	localparam int SW = (NUM_SEMS > 1) ? $clog2(NUM_SEMS) : 1;
	localparam int TW = $clog2(NUM_SEMS + 1);
	localparam int PW = (NUM_PROCS > 1) ? $clog2(NUM_PROCS) : 1;
	localparam int LW = $clog2(NUM_PROCS + 1);

	typedef struct packed {
		logic signed [15:0] cnt;
		logic [LW-1:0]      len;
		logic [PW-1:0]      head;
		logic [PW-1:0]      tail;
	} sem_ent_t;

	typedef enum logic [3:0] {
		S_IDLE, S_EXEC, S_DQ, S_DQ_EM, S_WALK, S_WALK_NX, S_POP, S_POP_EM, S_DONE
	} state_t;

	state_t state_q;

	// memories
	sem_ent_t       sem_mem [NUM_SEMS];
	logic [PW-1:0]  nxt_mem [NUM_PROCS];
	logic [PW-1:0]  lst_mem [NUM_PROCS];
	logic [SW-1:0]  stk_mem [NUM_SEMS];

	sem_ent_t       sem_rdata_q, sem_wdata;
	logic [PW-1:0]  nxt_rdata_q, lst_rdata_q, nxt_wdata, nxt_raddr, nxt_waddr;
	logic [PW-1:0]  lst_raddr;
	logic [SW-1:0]  stk_rdata_q, stk_raddr, sem_waddr, sem_raddr;
	logic           sem_we, nxt_we, lst_we, stk_we;

	// transaction and working registers
	op_t                op_q;
	logic [7:0]         sid_q;
	logic signed [15:0] amt_q;
	logic [5:0]         caller_q;
	logic signed [15:0] cnt_q;
	logic [LW-1:0]      len_q, idx_q;
	logic [PW-1:0]      head_q, tail_q, p_q;
	logic [15:0]        wakes_q;
	logic [TW-1:0]      free_top_q, min_top_q;
	logic [NUM_SEMS-1:0]  in_use_q;
	logic [NUM_PROCS-1:0] waiting_q;

	// EXEC decode
	sem_ent_t           ent;
	logic signed [16:0] c17, amt17, neg_c;
	logic [SW-1:0]      sidx, new_id;
	logic [PW-1:0]      cidx;
	logic               sid_ok, caller_ok, create_ok;
	logic [15:0]        wakes_n;

	always_comb begin
		ent       = sem_rdata_q;
		c17       = {ent.cnt[15], ent.cnt};
		amt17     = {amt_q[15], amt_q};
		neg_c     = -c17;
		sidx      = sid_q[SW-1:0];
		cidx      = PW'(caller_q - 6'd1);
		sid_ok    = (32'(sid_q) < NUM_SEMS) && in_use_q[sidx];
		caller_ok = (caller_q != 6'd0) && (32'(caller_q) <= NUM_PROCS) && !waiting_q[cidx];
		create_ok = !amt_q[15] && (free_top_q != '0);
		new_id    = (TW'(stk_raddr) < min_top_q) ? stk_raddr : stk_rdata_q;
		if (c17 < 0)
			wakes_n = (neg_c < amt17) ? neg_c[15:0] : amt_q;
		else
			wakes_n = '0;
	end

	always_comb begin
		sem_raddr = sem_id[SW-1:0];
		stk_raddr = SW'(free_top_q - TW'(1));
		nxt_raddr = (state_q == S_DQ) ? head_q : p_q;
		lst_raddr = PW'(idx_q - LW'(1));
		sem_we    = 1'b0;
		sem_waddr = sidx;
		sem_wdata = ent;
		nxt_we    = 1'b0;
		nxt_waddr = ent.tail;
		nxt_wdata = cidx;
		lst_we    = (state_q == S_WALK) && (idx_q < len_q);
		stk_we    = 1'b0;
		unique case (state_q)
			S_EXEC: begin
				if (op_q == OP_CREATE) begin
					sem_we    = create_ok;
					sem_waddr = new_id;
					sem_wdata = '{cnt: amt_q, len: '0, head: '0, tail: '0};
				end else if (sid_ok) begin
					sem_wdata.cnt = 16'(c17 - 17'sd1);
					if (op_q == OP_WAIT && c17 != CNT_MIN) begin
						if (c17 <= 0) begin
							sem_we         = caller_ok;
							nxt_we         = caller_ok && (ent.len != '0);
							sem_wdata.len  = ent.len + LW'(1);
							sem_wdata.head = (ent.len == '0) ? cidx : ent.head;
							sem_wdata.tail = cidx;
						end else begin
							sem_we = 1'b1;
						end
					end else if (op_q == OP_TRY) begin
						sem_we = (c17 > 0);
					end
				end
			end
			S_DONE: begin
				sem_we    = 1'b1;
				sem_wdata = '{cnt: cnt_q, len: len_q, head: head_q, tail: tail_q};
				if (op_q == OP_DELETE || op_q == OP_RESET)
					sem_wdata.len = '0;
				stk_we = (op_q == OP_DELETE) && (32'(free_top_q) < NUM_SEMS);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		sem_rdata_q <= sem_mem[sem_raddr];
		nxt_rdata_q <= nxt_mem[nxt_raddr];
		lst_rdata_q <= lst_mem[lst_raddr];
		stk_rdata_q <= stk_mem[stk_raddr];
		if (sem_we)
			sem_mem[sem_waddr] <= sem_wdata;
		if (nxt_we)
			nxt_mem[nxt_waddr] <= nxt_wdata;
		if (lst_we)
			lst_mem[idx_q[PW-1:0]] <= p_q;
		if (stk_we)
			stk_mem[free_top_q[SW-1:0]] <= sidx;
	end

	assign busy = (state_q != S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			strobe     <= 1'b0;
			status     <= ST_OK;
			value      <= '0;
			woken_pid  <= '0;
			last       <= 1'b0;
			free_top_q <= TW'(NUM_SEMS);
			min_top_q  <= TW'(NUM_SEMS);
			in_use_q   <= '0;
			waiting_q  <= '0;
		end else begin
			strobe    <= 1'b0;
			value     <= '0;
			woken_pid <= '0;
			last      <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						op_q     <= op_t'(operation);
						sid_q    <= sem_id;
						amt_q    <= amount;
						caller_q <= caller_pid;
						state_q  <= S_EXEC;
					end
				end
				S_EXEC: begin
					cnt_q   <= ent.cnt;
					len_q   <= ent.len;
					head_q  <= ent.head;
					tail_q  <= ent.tail;
					p_q     <= ent.head;
					idx_q   <= '0;
					wakes_q <= '0;
					state_q <= S_IDLE;
					strobe  <= 1'b1;
					last    <= 1'b1;
					status  <= ST_OK;
					if (op_q == OP_CREATE) begin
						if (create_ok) begin
							free_top_q       <= free_top_q - TW'(1);
							if (free_top_q - TW'(1) < min_top_q)
								min_top_q <= free_top_q - TW'(1);
							in_use_q[new_id] <= 1'b1;
							value            <= 16'(new_id);
						end else begin
							status <= ST_INVALID;
						end
					end else if (!sid_ok) begin
						status <= ST_INVALID;
					end else begin
						unique case (op_q)
							OP_WAIT: begin
								if (c17 == CNT_MIN)
									status <= ST_OVERFLOW;
								else if (c17 <= 0) begin
									if (caller_ok) begin
										waiting_q[cidx] <= 1'b1;
										status          <= ST_BLOCKED;
									end else
										status <= ST_INVALID;
								end
							end
							OP_TRY: begin
								if (c17 <= 0)
									status <= ST_UNAVAIL;
							end
							OP_SIGNAL: begin
								if (c17 == CNT_MAX)
									status <= ST_OVERFLOW;
								else begin
									strobe  <= 1'b0;
									last    <= 1'b0;
									cnt_q   <= 16'(c17 + 17'sd1);
									wakes_q <= (c17 < 0) ? 16'd1 : 16'd0;
									state_q <= S_DQ;
								end
							end
							OP_SIGNALN: begin
								if (amt_q[15])
									status <= ST_UNAVAIL;
								else if (c17 > 0 && (CNT_MAX - c17) < amt17)
									status <= ST_OVERFLOW;
								else begin
									strobe  <= 1'b0;
									last    <= 1'b0;
									cnt_q   <= 16'(c17 + amt17);
									wakes_q <= wakes_n;
									state_q <= S_DQ;
								end
							end
							OP_COUNT: begin
								value <= ent.cnt;
							end
							OP_DELETE: begin
								strobe  <= 1'b0;
								last    <= 1'b0;
								state_q <= S_WALK;
							end
							OP_RESET: begin
								if (amt_q[15])
									status <= ST_INVALID;
								else begin
									strobe  <= 1'b0;
									last    <= 1'b0;
									cnt_q   <= amt_q;
									state_q <= S_WALK;
								end
							end
							default: ;
						endcase
					end
				end
				S_DQ: begin
					if (wakes_q != '0 && len_q != '0)
						state_q <= S_DQ_EM;
					else
						state_q <= S_DONE;
				end
				S_DQ_EM: begin
					strobe            <= 1'b1;
					status            <= ST_WOKEN;
					woken_pid         <= 6'(head_q) + 6'd1;
					waiting_q[head_q] <= 1'b0;
					head_q            <= nxt_rdata_q;
					len_q             <= len_q - LW'(1);
					wakes_q           <= wakes_q - 16'd1;
					state_q           <= S_DQ;
				end
				S_WALK: begin
					if (idx_q < len_q)
						state_q <= S_WALK_NX;
					else
						state_q <= S_POP;
				end
				S_WALK_NX: begin
					p_q     <= nxt_rdata_q;
					idx_q   <= idx_q + LW'(1);
					state_q <= S_WALK;
				end
				S_POP: begin
					if (idx_q != '0)
						state_q <= S_POP_EM;
					else
						state_q <= S_DONE;
				end
				S_POP_EM: begin
					strobe                 <= 1'b1;
					status                 <= (op_q == OP_DELETE) ? ST_WOKEN_DEL : ST_WOKEN_RST;
					woken_pid              <= 6'(lst_rdata_q) + 6'd1;
					waiting_q[lst_rdata_q] <= 1'b0;
					idx_q                  <= idx_q - LW'(1);
					state_q                <= S_POP;
				end
				S_DONE: begin
					strobe  <= 1'b1;
					last    <= 1'b1;
					status  <= ST_OK;
					state_q <= S_IDLE;
					if (op_q == OP_DELETE) begin
						in_use_q[sidx] <= 1'b0;
						if (32'(free_top_q) < NUM_SEMS)
							free_top_q <= free_top_q + TW'(1);
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule
